// ===== src/pwee_pkg.sv =====
// shared types and constants of the polygon wall edge extractor
`timescale 1ns / 1ps
package pwee_pkg;

	localparam int COORD_W   = 24;
	localparam int NB_W      = 16;
	localparam int FLAG_W    = 16;
	localparam int MIN_W     = 20;
	localparam int CFG_W     = 20;
	localparam int NRM_W     = 16;
	localparam int MAG_W     = 15;
	localparam int SQ_W      = 50;
	localparam int ROOT_W    = 84;
	localparam int MUL_W     = 32;
	localparam logic [3:0] ROOT_TOP_BIT = 4'd14;
	localparam logic [MIN_W-1:0] MIN_LEN_RESET = 20'd655;
	localparam logic [MIN_W-1:0] NRM_ONE = 20'd16384;

	localparam logic REG_BLOCKED_MASK = 1'b0;
	localparam logic REG_MIN_LEN_SQ   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE,
		S_DIFF,
		S_MUL,
		S_CHK,
		S_RA,
		S_RB,
		S_OUT,
		S_NEXT,
		S_FIN
	} state_t;

endpackage

// ===== src/polygon_wall_edge_extractor_core.sv =====
// polygon wall edge extractor: vertex store, shared multiplier and square-root sequencer
//
// vertices of one polygon enter one per transfer: start high while busy is low.
// the user must write configuration through cfg_we/cfg_addr/cfg_wdata only while
// the block is idle; the block itself does not enforce this. a non-final vertex
// leaves busy low, and so does a final vertex of a skipped polygon. otherwise the
// final vertex raises busy while the edges are walked: S_EDGE and S_NEXT for an
// edge that is not a wall; S_EDGE, S_DIFF, S_MUL, S_CHK and S_NEXT for a wall edge
// below the minimum length; for a wall edge that gives a result also S_RA, S_RB and
// S_OUT before S_NEXT; then S_FIN closes. a wall edge uses the shared 32x32 multiplier
// (six products) and the bit-by-bit rounding root search, 15 bits per component.
// each result is held back until the next one is known, so that last_edge can be
// marked; done strobes for one cycle per result, the final one in the first cycle
// with busy low again. results cannot be stalled.
// reset clears the vertex count, wall marks, skip flag and the registers
// (blocked_mask 0, min_edge_len_sq 655); the vertex store itself is not cleared.
`timescale 1ns / 1ps
module polygon_wall_edge_extractor_core
	import pwee_pkg::*;
#(
	parameter int MAX_POLY_VERTS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [COORD_W-1:0]  vertex_x,
	input  logic signed [COORD_W-1:0]  vertex_y,
	input  logic signed [COORD_W-1:0]  vertex_z,
	input  logic        [NB_W-1:0]     edge_neighbor,
	input  logic                       poly_offmesh,
	input  logic        [FLAG_W-1:0]   poly_flags,
	input  logic                       last_vertex,
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic        [CFG_W-1:0]    cfg_wdata,
	output logic                       done,
	output logic signed [COORD_W-1:0]  edge_start_x,
	output logic signed [COORD_W-1:0]  edge_start_y,
	output logic signed [COORD_W-1:0]  edge_start_z,
	output logic signed [COORD_W-1:0]  edge_end_x,
	output logic signed [COORD_W-1:0]  edge_end_y,
	output logic signed [COORD_W-1:0]  edge_end_z,
	output logic signed [NRM_W-1:0]    outward_x,
	output logic signed [NRM_W-1:0]    outward_y,
	output logic                       last_edge
);

	localparam int IDX_W = $clog2(MAX_POLY_VERTS);
	localparam int CNT_W = $clog2(MAX_POLY_VERTS + 1);
	localparam int E_W   = IDX_W + 1;
	localparam int SUM_W = COORD_W + CNT_W;
	localparam int D_W   = COORD_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POLY_VERTS);

	state_t state_q, state_d;

	logic [FLAG_W-1:0] blocked_mask_q;
	logic [MIN_W-1:0]  min_len_q;

	logic [COORD_W-1:0] mem_x [MAX_POLY_VERTS];
	logic [COORD_W-1:0] mem_y [MAX_POLY_VERTS];
	logic [COORD_W-1:0] mem_z [MAX_POLY_VERTS];
	logic [MAX_POLY_VERTS-1:0] wall_q;
	logic [CNT_W-1:0] cnt_q;
	logic             skip_q;
	logic signed [SUM_W-1:0] sumx_q, sumy_q;

	logic signed [COORD_W-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
	logic [IDX_W-1:0] e_q, f_idx;
	logic [E_W-1:0]   e_p1;
	logic             e_last;

	logic signed [D_W-1:0] dx_q, dy_q, hsx_q, hsy_q;
	logic [2:0] st_q;
	logic signed [MUL_W-1:0] mul_a, mul_b, mx_q, my_q, sum2x, sum2y;
	logic signed [2*MUL_W-1:0] prod, dot_q;
	logic [SQ_W-1:0] sqx_q, sqy_q, s_q, s_sum;

	logic [3:0]        k_q;
	logic              comp_q;
	logic [MAG_W-1:0]  n_q;
	logic [ROOT_W-1:0] p_q, q_q, pc_q, qc_q, s_ext, t_val, v_val;
	logic [4:0]        sh1, sh2;
	logic              c_zero, fit;
	logic [MAG_W-1:0]  n_fit, mag;
	logic              neg;
	logic signed [NRM_W-1:0] nrm, ox_q, oy_q;

	logic acc, skip_now, store_en;
	logic [CNT_W-1:0] cnt_next;
	logic short_edge;

	logic              pend_q;
	logic signed [COORD_W-1:0] pend_sx_q, pend_sy_q, pend_sz_q, pend_ex_q, pend_ey_q, pend_ez_q;
	logic signed [NRM_W-1:0]   pend_ox_q, pend_oy_q;
	logic              done_q, last_q;
	logic signed [COORD_W-1:0] o_sx_q, o_sy_q, o_sz_q, o_ex_q, o_ey_q, o_ez_q;
	logic signed [NRM_W-1:0]   o_ox_q, o_oy_q;

	assign acc      = start && !busy;
	assign skip_now = skip_q || poly_offmesh || ((poly_flags & blocked_mask_q) != '0);
	assign store_en = cnt_q < CNT_MAX;
	assign cnt_next = store_en ? cnt_q + 1'b1 : cnt_q;

	assign e_p1   = {1'b0, e_q} + 1'b1;
	assign e_last = e_p1 == E_W'(cnt_q);
	assign f_idx  = e_last ? '0 : e_p1[IDX_W-1:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_mask_q <= '0;
			min_len_q      <= MIN_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCKED_MASK: blocked_mask_q <= cfg_wdata[FLAG_W-1:0];
				REG_MIN_LEN_SQ:   min_len_q      <= cfg_wdata[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// vertex store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (acc && store_en) begin
			mem_x[cnt_q[IDX_W-1:0]] <= vertex_x;
			mem_y[cnt_q[IDX_W-1:0]] <= vertex_y;
			mem_z[cnt_q[IDX_W-1:0]] <= vertex_z;
		end
		if (state_q == S_EDGE) begin
			x0_q <= mem_x[e_q];
			y0_q <= mem_y[e_q];
			z0_q <= mem_z[e_q];
			x1_q <= mem_x[f_idx];
			y1_q <= mem_y[f_idx];
			z1_q <= mem_z[f_idx];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (acc && last_vertex && !skip_now) state_d = S_EDGE;
			S_EDGE: state_d = wall_q[e_q] ? S_DIFF : S_NEXT;
			S_DIFF: state_d = S_MUL;
			S_MUL:  if (st_q == 3'd5) state_d = S_CHK;
			S_CHK:  state_d = short_edge ? S_NEXT : S_RA;
			S_RA:   state_d = S_RB;
			S_RB: begin
				if (k_q != '0)   state_d = S_RA;
				else if (comp_q) state_d = S_OUT;
				else             state_d = S_RA;
			end
			S_OUT:  state_d = S_NEXT;
			S_NEXT: state_d = e_last ? S_FIN : S_EDGE;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy = state_q != S_IDLE;
	end

	// shared multiplier operands
	assign sum2x = MUL_W'(sumx_q) <<< 1;
	assign sum2y = MUL_W'(sumy_q) <<< 1;
	always_comb begin
		case (st_q)
			3'd0: begin mul_a = MUL_W'(dx_q); mul_b = MUL_W'(dx_q); end
			3'd1: begin mul_a = MUL_W'(dy_q); mul_b = MUL_W'(dy_q); end
			3'd2: begin mul_a = MUL_W'(hsx_q); mul_b = MUL_W'({1'b0, cnt_q}); end
			3'd3: begin mul_a = MUL_W'(hsy_q); mul_b = MUL_W'({1'b0, cnt_q}); end
			3'd4: begin mul_a = -MUL_W'(dy_q); mul_b = mx_q; end
			default: begin mul_a = MUL_W'(dx_q); mul_b = my_q; end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign s_sum      = sqx_q + sqy_q;
	assign short_edge = s_sum < SQ_W'(min_len_q);

	// root search: largest n with (2n-1)^2 * s <= c^2 * 2^30, p = (2n)^2 s, q = 2n s
	assign s_ext  = ROOT_W'(s_q);
	assign sh1    = {1'b0, k_q} + 5'd1;
	assign sh2    = {k_q, 1'b0} + 5'd2;
	assign t_val  = comp_q ? (ROOT_W'(sqx_q) << 30) : (ROOT_W'(sqy_q) << 30);
	assign v_val  = pc_q - (qc_q << 1) + s_ext;
	assign fit    = v_val <= t_val;
	assign c_zero = comp_q ? (dx_q == '0) : (dy_q == '0);
	assign n_fit  = fit ? (n_q | (MAG_W'(1) << k_q)) : n_q;
	assign mag    = c_zero ? '0 : n_fit;
	// sign of the component, turned over when the normal faces the centroid
	assign neg    = (comp_q ? dx_q[D_W-1] : (dy_q > 0)) ^ dot_q[2*MUL_W-1];
	assign nrm    = neg ? -NRM_W'(mag) : NRM_W'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			skip_q  <= 1'b0;
			wall_q  <= '0;
			sumx_q  <= '0;
			sumy_q  <= '0;
			e_q     <= '0;
			st_q    <= '0;
			k_q     <= '0;
			comp_q  <= 1'b0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (last_vertex && !skip_now) begin
							cnt_q <= cnt_next;
							e_q   <= '0;
							if (store_en) wall_q[cnt_q[IDX_W-1:0]] <= edge_neighbor == '0;
						end else if (last_vertex) begin
							cnt_q  <= '0;
							skip_q <= 1'b0;
							wall_q <= '0;
							sumx_q <= '0;
							sumy_q <= '0;
						end else begin
							cnt_q  <= cnt_next;
							skip_q <= skip_now;
							if (store_en) begin
								wall_q[cnt_q[IDX_W-1:0]] <= edge_neighbor == '0;
								sumx_q <= sumx_q + SUM_W'(vertex_x);
								sumy_q <= sumy_q + SUM_W'(vertex_y);
							end
						end
						if (last_vertex && !skip_now && store_en) begin
							sumx_q <= sumx_q + SUM_W'(vertex_x);
							sumy_q <= sumy_q + SUM_W'(vertex_y);
						end
					end
				end
				S_DIFF: st_q <= '0;
				S_MUL:  st_q <= st_q + 3'd1;
				S_CHK: begin
					k_q    <= ROOT_TOP_BIT;
					comp_q <= 1'b0;
				end
				S_RB: begin
					if (k_q != '0) begin
						k_q <= k_q - 4'd1;
					end else begin
						k_q    <= ROOT_TOP_BIT;
						comp_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (pend_q) done_q <= 1'b1;
					pend_q <= 1'b1;
				end
				S_NEXT: e_q <= f_idx;
				S_FIN: begin
					if (pend_q) done_q <= 1'b1;
					pend_q <= 1'b0;
					cnt_q  <= '0;
					skip_q <= 1'b0;
					wall_q <= '0;
					sumx_q <= '0;
					sumy_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_DIFF: begin
				dx_q  <= D_W'(x1_q) - D_W'(x0_q);
				dy_q  <= D_W'(y1_q) - D_W'(y0_q);
				hsx_q <= D_W'(x1_q) + D_W'(x0_q);
				hsy_q <= D_W'(y1_q) + D_W'(y0_q);
			end
			S_MUL: begin
				case (st_q)
					3'd0: sqx_q <= prod[SQ_W-1:0];
					3'd1: sqy_q <= prod[SQ_W-1:0];
					3'd2: mx_q  <= prod[MUL_W-1:0] - sum2x;
					3'd3: my_q  <= prod[MUL_W-1:0] - sum2y;
					3'd4: dot_q <= prod;
					default: dot_q <= dot_q + prod;
				endcase
			end
			S_CHK: begin
				s_q <= s_sum;
				p_q <= '0;
				q_q <= '0;
				n_q <= '0;
			end
			S_RA: begin
				pc_q <= p_q + (q_q << (sh1 + 5'd1)) + (s_ext << sh2);
				qc_q <= q_q + (s_ext << sh1);
			end
			S_RB: begin
				if (k_q != '0) begin
					n_q <= n_fit;
					if (fit) begin
						p_q <= pc_q;
						q_q <= qc_q;
					end
				end else begin
					if (!comp_q) ox_q <= nrm;
					else         oy_q <= nrm;
					p_q <= '0;
					q_q <= '0;
					n_q <= '0;
				end
			end
			S_OUT: begin
				o_sx_q <= pend_sx_q; o_sy_q <= pend_sy_q; o_sz_q <= pend_sz_q;
				o_ex_q <= pend_ex_q; o_ey_q <= pend_ey_q; o_ez_q <= pend_ez_q;
				o_ox_q <= pend_ox_q; o_oy_q <= pend_oy_q;
				last_q <= 1'b0;
				pend_sx_q <= x0_q; pend_sy_q <= y0_q; pend_sz_q <= z0_q;
				pend_ex_q <= x1_q; pend_ey_q <= y1_q; pend_ez_q <= z1_q;
				pend_ox_q <= ox_q; pend_oy_q <= oy_q;
			end
			S_FIN: begin
				o_sx_q <= pend_sx_q; o_sy_q <= pend_sy_q; o_sz_q <= pend_sz_q;
				o_ex_q <= pend_ex_q; o_ey_q <= pend_ey_q; o_ez_q <= pend_ez_q;
				o_ox_q <= pend_ox_q; o_oy_q <= pend_oy_q;
				last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign edge_start_x = o_sx_q;
	assign edge_start_y = o_sy_q;
	assign edge_start_z = o_sz_q;
	assign edge_end_x   = o_ex_q;
	assign edge_end_y   = o_ey_q;
	assign edge_end_z   = o_ez_q;
	assign outward_x    = o_ox_q;
	assign outward_y    = o_oy_q;
	assign last_edge    = last_q;

endmodule

// ===== src/pwee_checker.sv =====
// port-level checker of the polygon wall edge extractor and its bind
`timescale 1ns / 1ps
module pwee_checker
	import pwee_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      last_vertex,
	input logic                      done,
	input logic                      last_edge,
	input logic signed [NRM_W-1:0]   outward_x,
	input logic signed [NRM_W-1:0]   outward_y
);

	localparam logic signed [NRM_W-1:0] ONE = NRM_W'(NRM_ONE);

	// a vertex that does not close the polygon never starts the edge walk
	a_mid_vertex_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_vertex |=> !busy)
		else $error("busy after a non-final vertex transfer");

	// results come only out of an edge walk
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding edge walk");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_edge |=> !done)
		else $error("result directly after the final edge of a polygon");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outward_x <= ONE && outward_x >= -ONE && outward_y <= ONE && outward_y >= -ONE)
		else $error("normal component beyond one");

endmodule

bind polygon_wall_edge_extractor_core pwee_checker u_pwee_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.last_vertex (last_vertex),
	.done        (done),
	.last_edge   (last_edge),
	.outward_x   (outward_x),
	.outward_y   (outward_y)
);
